>>> rtl/dpb_pkg.sv
// shared types and constants of the depth pixel back-projection block
// no dependencies
`default_nettype none

package dpb_pkg;

  // low bits of row and column taken into account
  localparam int unsigned COORD_BITS = 11;

  localparam int unsigned ROW_W   = 11;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned CENTER_W = 12;
  localparam int unsigned RECIP_W  = 25;
  localparam int unsigned Z_W      = 23;
  localparam int unsigned COORD_W  = 32;

  // coordinate bits actually present in the input fields
  localparam int unsigned COORD_USE = (COORD_BITS < ROW_W) ? COORD_BITS : ROW_W;
  localparam int unsigned TWICE_W   = COORD_USE + 1;
  localparam int unsigned MAG_W     = (TWICE_W > CENTER_W) ? TWICE_W : CENTER_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = RECIP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DEPTH = 3'd4;

  localparam logic [CENTER_W-1:0] CENTER_X_RST  = 12'd651;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST  = 12'd507;
  localparam logic [RECIP_W-1:0]  INV_FX_RST    = 25'd32388;
  localparam logic [RECIP_W-1:0]  INV_FY_RST    = 25'd32327;
  localparam logic [RECIP_W-1:0]  INV_DEPTH_RST = 25'd16777;

  typedef struct packed {
    logic [ROW_W-1:0]   pixel_row;
    logic [ROW_W-1:0]   pixel_col;
    logic [DEPTH_W-1:0] raw_depth;
    logic [COLOR_W-1:0] blue_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] red_in;
  } pixel_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [Z_W-1:0]            point_z;
    logic [COLOR_W-1:0]        blue_out;
    logic [COLOR_W-1:0]        green_out;
    logic [COLOR_W-1:0]        red_out;
  } point_t;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } color_t;

endpackage

`default_nettype wire

>>> rtl/dpb_axis.sv
// one lateral axis of the back-projection: offset, two multiplies, round and saturate
// depends on dpb_pkg; four register stages, z joins the product after the second
`default_nettype none

module dpb_axis import dpb_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic [COORD_USE-1:0] coord_i,
  input  wire logic [CENTER_W-1:0] center2_i,
  input  wire logic [RECIP_W-1:0]  inv_f_i,
  input  wire logic [Z_W-1:0]      z_i,
  output logic [COORD_W-1:0]       result_o
);

  localparam int unsigned MF_W  = MAG_W + RECIP_W;
  localparam int unsigned PR_W  = MF_W + Z_W;
  localparam int unsigned Q_W   = PR_W - 24;
  localparam logic [Q_W-1:0] NEG_LIM = Q_W'(64'h8000_0000);
  localparam logic [Q_W-1:0] POS_LIM = Q_W'(64'h7FFF_FFFF);

  logic [MAG_W-1:0] twice, center, mag_d, mag_q;
  logic             neg_d, neg1_q, neg2_q, neg3_q;
  logic [MF_W-1:0]  magf_q;
  logic [PR_W-1:0]  prod_q;
  logic [PR_W:0]    rnd;
  logic [Q_W-1:0]   q16, sat;
  logic [COORD_W-1:0] result_d, result_q;

  // stage 1: offset in half pixels, as magnitude and sign
  always_comb begin
    twice  = MAG_W'({coord_i, 1'b0});
    center = MAG_W'(center2_i);
    neg_d  = twice < center;
    mag_d  = neg_d ? (center - twice) : (twice - center);
  end

  // stage 4: round half away from zero to q.16, clamp, apply sign
  always_comb begin
    rnd = {1'b0, prod_q} + (PR_W+1)'(1 << 24);
    q16 = rnd[PR_W:25];
    if (neg3_q) begin
      sat      = (q16 > NEG_LIM) ? NEG_LIM : q16;
      result_d = ~sat[COORD_W-1:0] + COORD_W'(1);
    end else begin
      sat      = (q16 > POS_LIM) ? POS_LIM : q16;
      result_d = sat[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    neg1_q   <= neg_d;
    magf_q   <= MF_W'(mag_q) * MF_W'(inv_f_i);
    neg2_q   <= neg1_q;
    prod_q   <= PR_W'(magf_q) * PR_W'(z_i);
    neg3_q   <= neg2_q;
    result_q <= result_d;
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

>>> rtl/depth_pixel_backprojection.sv
// top level of the pinhole depth pixel back-projection pipeline
// depends on dpb_pkg and dpb_axis
`default_nettype none

// Takes one RGB-D pixel per clock (start while busy is low; busy is
// always low) and returns its colored 3-D point as a one-cycle strobe
// on point_valid_o with point_o. A pixel with zero depth gives no
// point. The four stages are: depth multiply and pixel offset, z
// rounding with the offset times the focal reciprocal, the multiply by
// z, then rounding and saturation. Points always leave in pixel order
// and cannot be held off. Registers are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must write them only while no
// pixel is in flight, as the block itself does not enforce it.
module depth_pixel_backprojection import dpb_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire pixel_t                pixel_i,
  output logic                       point_valid_o,
  output point_t                     point_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned ZP_W = DEPTH_W + RECIP_W;
  localparam logic [ZP_W-8:0] Z_LIM = (ZP_W-7)'((1 << Z_W) - 1);

  logic [CENTER_W-1:0] center_x_q, center_y_q;
  logic [RECIP_W-1:0]  inv_fx_q, inv_fy_q, inv_depth_q;

  logic [3:0]      valid_q;
  logic            accept;
  logic [ZP_W-1:0] zprod_q;
  logic [ZP_W:0]   zrnd;
  logic [ZP_W-8:0] zfull;
  logic [Z_W-1:0]  z_d, z1_q, z2_q, z3_q;
  color_t          color_q [4];
  logic [COORD_W-1:0] x_res, y_res;

  assign busy   = 1'b0;
  assign accept = start && !busy && (pixel_i.raw_depth != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= CENTER_X_RST;
      center_y_q  <= CENTER_Y_RST;
      inv_fx_q    <= INV_FX_RST;
      inv_fy_q    <= INV_FY_RST;
      inv_depth_q <= INV_DEPTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER_X:  center_x_q  <= cfg_wdata_i[CENTER_W-1:0];
        CFG_CENTER_Y:  center_y_q  <= cfg_wdata_i[CENTER_W-1:0];
        CFG_INV_FX:    inv_fx_q    <= cfg_wdata_i;
        CFG_INV_FY:    inv_fy_q    <= cfg_wdata_i;
        CFG_INV_DEPTH: inv_depth_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], accept};
    end
  end

  // z: q.24 product rounded to q.16 and clamped
  always_comb begin
    zrnd  = {1'b0, zprod_q} + (ZP_W+1)'(128);
    zfull = zrnd[ZP_W:8];
    z_d   = (zfull > Z_LIM) ? Z_W'(Z_LIM) : zfull[Z_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    zprod_q    <= ZP_W'(pixel_i.raw_depth) * ZP_W'(inv_depth_q);
    z1_q       <= z_d;
    z2_q       <= z1_q;
    z3_q       <= z2_q;
    color_q[0] <= '{blue: pixel_i.blue_in, green: pixel_i.green_in, red: pixel_i.red_in};
    color_q[1] <= color_q[0];
    color_q[2] <= color_q[1];
    color_q[3] <= color_q[2];
  end

  dpb_axis u_axis_x (
    .clk_i     (clk_i),
    .coord_i   (pixel_i.pixel_col[COORD_USE-1:0]),
    .center2_i (center_x_q),
    .inv_f_i   (inv_fx_q),
    .z_i       (z1_q),
    .result_o  (x_res)
  );

  dpb_axis u_axis_y (
    .clk_i     (clk_i),
    .coord_i   (pixel_i.pixel_row[COORD_USE-1:0]),
    .center2_i (center_y_q),
    .inv_f_i   (inv_fy_q),
    .z_i       (z1_q),
    .result_o  (y_res)
  );

  assign point_valid_o     = valid_q[3];
  assign point_o.point_x   = x_res;
  assign point_o.point_y   = y_res;
  assign point_o.point_z   = z3_q;
  assign point_o.blue_out  = color_q[3].blue;
  assign point_o.green_out = color_q[3].green;
  assign point_o.red_out   = color_q[3].red;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// self-checking testbench for depth_pixel_backprojection: directed and random pixels,
// predicted points compared field by field with what the block returns
// depends on dpb_pkg and the rtl of depth_pixel_backprojection
`timescale 1ns / 100ps

module tb_top import dpb_pkg::*; ;

  localparam int unsigned CYCLE_LIMIT = 200000;
  // pipeline is four deep; zero-depth pixels may still be in flight when the queue drains
  localparam int unsigned PIPE_SLACK = 10;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PIXELS_PER_PHASE = 90;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_INV_DEPTH + 1'b1;
  localparam logic [RECIP_W-1:0] RECIP_ONE = 25'd16777216;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  pixel_t pixel = '0;
  logic point_valid_o;
  point_t point_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // register copies used by the predictor
  logic [CENTER_W-1:0] cx2_copy = CENTER_X_RST;
  logic [CENTER_W-1:0] cy2_copy = CENTER_Y_RST;
  logic [RECIP_W-1:0] inv_fx_copy = INV_FX_RST;
  logic [RECIP_W-1:0] inv_fy_copy = INV_FY_RST;
  logic [RECIP_W-1:0] inv_depth_copy = INV_DEPTH_RST;

  point_t pending_points[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic idle_on = 1'b1;

  depth_pixel_backprojection dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .pixel_i      (pixel),
    .point_valid_o(point_valid_o),
    .point_o      (point_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one axis: offset in half pixels times z times the focal reciprocal, Q.41 down to Q.16
  function automatic logic [COORD_W-1:0] scale_offset(input logic [ROW_W-1:0] coord,
                                                      input logic [CENTER_W-1:0] center2,
                                                      input logic [Z_W-1:0] z,
                                                      input logic [RECIP_W-1:0] inv_f);
    logic [ROW_W-1:0] cmask;
    logic [63:0] twice;
    logic [63:0] mag;
    logic [63:0] q16;
    logic neg;
    cmask = ROW_W'((64'd1 << COORD_BITS) - 1);
    twice = 64'(coord & cmask) << 1;
    neg = twice < 64'(center2);
    mag = neg ? 64'(center2) - twice : twice - 64'(center2);
    q16 = (mag * 64'(z) * 64'(inv_f) + (64'd1 << 24)) >> 25;
    if (neg) begin
      if (q16 > 64'h8000_0000) q16 = 64'h8000_0000;
      return COORD_W'(64'd0 - q16);
    end
    if (q16 > 64'h7FFF_FFFF) q16 = 64'h7FFF_FFFF;
    return COORD_W'(q16);
  endfunction

  function automatic point_t project_pixel(input pixel_t px);
    logic [63:0] zw;
    point_t pt;
    zw = (64'(px.raw_depth) * 64'(inv_depth_copy) + 64'd128) >> 8;
    if (zw > 64'h7F_FFFF) zw = 64'h7F_FFFF;
    pt.point_z = Z_W'(zw);
    pt.point_x = scale_offset(px.pixel_col, cx2_copy, pt.point_z, inv_fx_copy);
    pt.point_y = scale_offset(px.pixel_row, cy2_copy, pt.point_z, inv_fy_copy);
    pt.blue_out = px.blue_in;
    pt.green_out = px.green_in;
    pt.red_out = px.red_in;
    return pt;
  endfunction

  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && point_valid_o) begin
      if (pending_points.size() == 0) begin
        $error("point returned with none expected: x %0d y %0d z %0d",
               point_o.point_x, point_o.point_y, point_o.point_z);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        if (point_o.point_x !== want.point_x) begin
          $error("point_x: expected %0d, got %0d", want.point_x, point_o.point_x);
          mismatches++;
        end
        if (point_o.point_y !== want.point_y) begin
          $error("point_y: expected %0d, got %0d", want.point_y, point_o.point_y);
          mismatches++;
        end
        if (point_o.point_z !== want.point_z) begin
          $error("point_z: expected %0d, got %0d", want.point_z, point_o.point_z);
          mismatches++;
        end
        if (point_o.blue_out !== want.blue_out) begin
          $error("blue_out: expected %0d, got %0d", want.blue_out, point_o.blue_out);
          mismatches++;
        end
        if (point_o.green_out !== want.green_out) begin
          $error("green_out: expected %0d, got %0d", want.green_out, point_o.green_out);
          mismatches++;
        end
        if (point_o.red_out !== want.red_out) begin
          $error("red_out: expected %0d, got %0d", want.red_out, point_o.red_out);
          mismatches++;
        end
      end
    end
  end

  // leaves start high on return so back-to-back requests need no gap
  task automatic send_pixel(input pixel_t px);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1'b1;
    pixel <= px;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (px.raw_depth != '0) pending_points = {pending_points, project_pixel(px)};
  endtask

  task automatic send_fields(input int row, input int col, input int depth,
                             input int blue, input int green, input int red);
    pixel_t px;
    px.pixel_row = ROW_W'(row);
    px.pixel_col = ROW_W'(col);
    px.raw_depth = DEPTH_W'(depth);
    px.blue_in = COLOR_W'(blue);
    px.green_in = COLOR_W'(green);
    px.red_in = COLOR_W'(red);
    send_pixel(px);
  endtask

  task automatic wait_for_points();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CENTER_X:  cx2_copy = CENTER_W'(data);
      CFG_CENTER_Y:  cy2_copy = CENTER_W'(data);
      CFG_INV_FX:    inv_fx_copy = data;
      CFG_INV_FY:    inv_fy_copy = data;
      CFG_INV_DEPTH: inv_depth_copy = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [RECIP_W-1:0] random_recip();
    case ($urandom_range(0, 3))
      0: return RECIP_W'($urandom_range(8000, 70000));
      1: return RECIP_W'($urandom_range(1, 255));
      2: return RECIP_W'($urandom_range(0, 2 ** 20));
      default: return RECIP_W'($urandom);
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.pixel_row = ROW_W'($urandom);
    px.pixel_col = ROW_W'($urandom);
    case ($urandom_range(0, 9))
      0: px.raw_depth = '0;
      1, 2, 3: px.raw_depth = DEPTH_W'($urandom_range(1, 4000));
      default: px.raw_depth = DEPTH_W'($urandom);
    endcase
    px.blue_in = COLOR_W'($urandom);
    px.green_in = COLOR_W'($urandom);
    px.red_in = COLOR_W'($urandom);
    return px;
  endfunction

  // reset intrinsics: principal point, image corners, depth extremes, no measurement
  task automatic test_reset_registers();
    send_fields(253, 325, 1000, 0, 0, 0);
    send_fields(0, 0, 65535, 255, 255, 255);
    send_fields(2047, 2047, 65535, 170, 85, 15);
    send_fields(2047, 0, 1, 85, 170, 240);
    send_fields(0, 2047, 0, 1, 2, 3);
    send_fields(1024, 1024, 32768, 128, 64, 32);
    send_fields(254, 326, 2, 255, 0, 255);
    wait_for_points();
  endtask

  task automatic test_register_extremes();
    // zero reciprocals zero the coordinates
    write_reg(CFG_CENTER_X, '0);
    write_reg(CFG_CENTER_Y, CFG_DATA_W'(4095));
    write_reg(CFG_INV_FX, '0);
    write_reg(CFG_INV_FY, '0);
    send_fields(2047, 2047, 40000, 9, 8, 7);
    send_fields(0, 0, 65535, 6, 5, 4);
    wait_for_points();
    write_reg(CFG_INV_DEPTH, '0);
    write_reg(CFG_INV_FX, RECIP_ONE);
    write_reg(CFG_INV_FY, RECIP_ONE);
    send_fields(100, 100, 65535, 3, 2, 1);
    wait_for_points();
    // reciprocals above one and all ones saturate z, x and y
    write_reg(CFG_INV_DEPTH, '1);
    write_reg(CFG_INV_FX, '1);
    write_reg(CFG_INV_FY, '1);
    send_fields(2047, 2047, 65535, 255, 0, 0);
    send_fields(0, 0, 65535, 0, 255, 0);
    send_fields(1, 1, 1, 0, 0, 255);
    wait_for_points();
    // smallest reciprocals, centers written with bits above their width
    write_reg(CFG_CENTER_X, CFG_DATA_W'(25'h1FF_F000));
    write_reg(CFG_CENTER_Y, '1);
    write_reg(CFG_INV_DEPTH, 25'd1);
    write_reg(CFG_INV_FX, 25'd1);
    write_reg(CFG_INV_FY, 25'd1);
    send_fields(2047, 0, 65535, 17, 34, 51);
    send_fields(0, 2047, 255, 68, 85, 102);
    wait_for_points();
  endtask

  task automatic test_unused_index();
    write_reg(CFG_CENTER_X, CFG_DATA_W'(651));
    write_reg(CFG_CENTER_Y, CFG_DATA_W'(507));
    write_reg(CFG_INV_FX, 25'd32388);
    write_reg(CFG_INV_FY, 25'd32327);
    write_reg(CFG_INV_DEPTH, 25'd16777);
    // writes past the register list must not disturb anything
    for (int k = int'(CFG_FIRST_UNUSED); k < 2 ** CFG_IDX_W; k++) begin
      write_reg(CFG_IDX_W'(k), '1);
    end
    send_fields(600, 10, 5000, 11, 22, 33);
    send_fields(3, 1200, 700, 44, 55, 66);
    wait_for_points();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase > 0) begin
        write_reg(CFG_CENTER_X, CFG_DATA_W'($urandom));
        write_reg(CFG_CENTER_Y, CFG_DATA_W'($urandom));
        write_reg(CFG_INV_FX, random_recip());
        write_reg(CFG_INV_FY, random_recip());
        write_reg(CFG_INV_DEPTH, random_recip());
      end
      // last phase streams with no gaps
      idle_on = (phase < RANDOM_PHASES - 1);
      for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
        send_pixel(random_pixel());
      end
      wait_for_points();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_registers();
    test_register_extremes();
    test_unused_index();
    test_random_phases();
    wait_for_points();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> depth_pixel_backprojection.f
rtl/dpb_pkg.sv
rtl/dpb_axis.sv
rtl/depth_pixel_backprojection.sv
verif/tb_top.sv
